@@ sv/mstb_pkg.sv @@
package mstb_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_REGISTER = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;

    // Slot modes. Code 3 is stored as stopped.
    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_UP      = 2'd1;
    localparam logic [1:0] MODE_DOWN    = 2'd2;

    // Response status codes.
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_BAD     = 3'd2;
    localparam logic [2:0] STAT_NOT_YET = 3'd3;
    localparam logic [2:0] STAT_FIRED   = 3'd4;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  slot_mode;
        logic [15:0] reload_value;
        logic [2:0]  query_slot;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  given_slot;
        logic [15:0] excess_ticks;
    } rsp_item_t;

    // One slot as held in the slot memory.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] counter;
        logic [15:0] reload;
    } slot_word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_QUERY,
        S_DONE
    } ctrl_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic tick_step;
        logic query_wb;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic qry_bad;
        logic sweep_more;
        logic wb_pending;
        logic out_free;
    } dp_sts_t;

endpackage

@@ sv/mstb_ctrl.sv @@
module mstb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        req_type,
    input  mstb_pkg::dp_sts_t sts,
    output mstb_pkg::dp_cmd_t cmd
);
    import mstb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_type == REQ_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else if (req_type == REQ_QUERY && !sts.qry_bad)
                    begin
                        state_next = S_QUERY;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (!sts.sweep_more && !sts.wb_pending)
                begin
                    state_next = S_DONE;
                end
            end
            S_QUERY:
            begin
                cmd.query_wb = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/mstb_datapath.sv @@
module mstb_datapath #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  mstb_pkg::req_item_t req,
    input  mstb_pkg::dp_cmd_t   cmd,
    output mstb_pkg::dp_sts_t   sts,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output mstb_pkg::rsp_item_t rsp
);
    import mstb_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

    // Slot memory: one write port, one registered read port.
    slot_word_t slot_mem [NUM_SLOTS];
    slot_word_t rd_data_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] sweep_reg;
    logic             wb_pending_reg;
    logic [IDX_W-1:0] wb_addr_reg;
    logic [15:0]      limit_reg;
    rsp_item_t        res_reg;
    rsp_item_t        rsp_reg;
    logic             rsp_valid_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_word_t       mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    logic             is_reg;
    logic             is_qry;
    logic             full;
    logic [CMP_W-1:0] id_ext;
    logic [CMP_W-1:0] count_ext;
    logic             id_bad;
    logic             sweep_more;
    logic             out_free;
    logic [1:0]       new_mode;
    slot_word_t       new_word;
    slot_word_t       tick_word;
    slot_word_t       q_word;
    logic [2:0]       q_status;
    logic [15:0]      q_excess;
    rsp_item_t        acc_res;

    assign is_reg     = (req.req_type == REQ_REGISTER);
    assign is_qry     = (req.req_type == REQ_QUERY);
    assign full       = (count_reg == CNT_W'(NUM_SLOTS));
    assign id_ext     = CMP_W'(req.query_slot);
    assign count_ext  = CMP_W'(count_reg);
    assign id_bad     = (id_ext >= count_ext);
    assign sweep_more = (sweep_reg < count_reg);
    assign out_free   = !rsp_valid_reg || rsp_ready;

    assign sts.qry_bad    = id_bad;
    assign sts.sweep_more = sweep_more;
    assign sts.wb_pending = wb_pending_reg;
    assign sts.out_free   = out_free;

    // New slot on register: an unknown mode is stored as stopped.
    always_comb
    begin
        new_mode = (req.slot_mode == MODE_UP || req.slot_mode == MODE_DOWN) ?
                   req.slot_mode : MODE_STOPPED;
        new_word.mode    = new_mode;
        new_word.reload  = req.reload_value;
        new_word.counter = (new_mode == MODE_UP) ? 16'd0 : req.reload_value;
    end

    // One slot's counter after a tick.
    always_comb
    begin
        tick_word = rd_data_reg;
        if (rd_data_reg.mode == MODE_DOWN)
        begin
            if (rd_data_reg.counter != 16'd0)
            begin
                tick_word.counter = rd_data_reg.counter - 16'd1;
            end
        end
        else if (rd_data_reg.mode == MODE_UP)
        begin
            if (rd_data_reg.counter < limit_reg)
            begin
                tick_word.counter = rd_data_reg.counter + 16'd1;
            end
        end
    end

    // Query of an allocated slot.
    always_comb
    begin
        q_word   = rd_data_reg;
        q_status = STAT_BAD;
        q_excess = 16'd0;
        if (rd_data_reg.mode == MODE_UP)
        begin
            if (rd_data_reg.reload > rd_data_reg.counter)
            begin
                q_status = STAT_NOT_YET;
            end
            else
            begin
                q_status       = STAT_FIRED;
                q_excess       = rd_data_reg.counter - rd_data_reg.reload;
                q_word.counter = 16'd0;
            end
        end
        else if (rd_data_reg.mode == MODE_DOWN)
        begin
            if (rd_data_reg.counter != 16'd0)
            begin
                q_status = STAT_NOT_YET;
            end
            else
            begin
                q_status       = STAT_FIRED;
                q_word.counter = rd_data_reg.reload;
            end
        end
    end

    // Result known at accept time for everything but a good query.
    always_comb
    begin
        acc_res.status       = STAT_OK;
        acc_res.given_slot   = 3'd0;
        acc_res.excess_ticks = 16'd0;
        if (is_reg)
        begin
            if (full)
            begin
                acc_res.status = STAT_FULL;
            end
            else
            begin
                acc_res.given_slot = count_ext[2:0];
            end
        end
        else if (is_qry && id_bad)
        begin
            acc_res.status = STAT_BAD;
        end
    end

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wb_addr_reg;
        mem_wdata = tick_word;
        mem_re    = 1'b0;
        mem_raddr = sweep_reg[IDX_W-1:0];
        if (cmd.accept && is_reg && !full)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[IDX_W-1:0];
            mem_wdata = new_word;
        end
        if (cmd.accept && is_qry)
        begin
            mem_re    = 1'b1;
            mem_raddr = id_ext[IDX_W-1:0];
        end
        if (cmd.tick_step)
        begin
            mem_we = wb_pending_reg;
            mem_re = sweep_more;
        end
        if (cmd.query_wb)
        begin
            mem_we    = 1'b1;
            mem_wdata = q_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sweep_reg      <= '0;
            wb_pending_reg <= 1'b0;
            limit_reg      <= LIMIT_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                sweep_reg      <= '0;
                wb_pending_reg <= 1'b0;
                if (is_reg && !full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else if (cmd.tick_step)
            begin
                wb_pending_reg <= sweep_more;
                if (sweep_more)
                begin
                    sweep_reg <= sweep_reg + CNT_W'(1);
                end
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_reg <= acc_res;
            if (is_qry)
            begin
                wb_addr_reg <= id_ext[IDX_W-1:0];
            end
        end
        else if (cmd.tick_step && sweep_more)
        begin
            wb_addr_reg <= sweep_reg[IDX_W-1:0];
        end
        if (cmd.query_wb)
        begin
            res_reg.status       <= q_status;
            res_reg.given_slot   <= 3'd0;
            res_reg.excess_ticks <= q_excess;
        end
        if (cmd.finish)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_SLOTS))
        else $error("allocated slot count exceeds the bank size");

    a_tick_wb_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick_step && wb_pending_reg) |-> (CNT_W'(wb_addr_reg) < count_reg))
        else $error("tick write-back to an unallocated slot");

    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free)
        else $error("response loaded while the output register is held");

    a_query_wb_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.query_wb |-> $past(cmd.accept))
        else $error("query write-back without a read in the previous cycle");

endmodule

@@ sv/multi_slot_tick_trigger_bank_unit.sv @@
// Bank of tick-driven trigger slots.
//
// Requests enter on req_valid/req_ready with the payload in req; every
// request produces exactly one response item on rsp_valid/rsp_ready with
// the payload in rsp. A request is a tick, a slot registration or a slot
// query. The user writes the saturation limit for count-up slots through
// cfg_wr_en/cfg_wr_data while the block is idle; it does not enforce this.
//
// Sequencing: the block works on one item at a time. A registration, an
// unknown request or a query of an unallocated slot goes from acceptance
// straight to loading the response; a good query first reads the memory,
// then evaluates and writes back. A tick sweeps the allocated slots through
// the single slot memory, one slot per cycle with read and write-back
// overlapped. The next item is accepted the cycle after the response is
// loaded.
//
// A stalled receiver holds the finished item in the output register and
// the next item waits for it. Reset empties the bank, sets the limit to
// 65535 and drops any response in flight; no clearing pass is needed
// because the contents of an unallocated slot are never used.
module multi_slot_tick_trigger_bank_unit #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mstb_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mstb_pkg::rsp_item_t rsp,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);
    import mstb_pkg::*;

    // Command and status between the sequencer and the datapath.
    dp_cmd_t cmd;
    dp_sts_t sts;

    // The controller decides when items are accepted, swept and answered.
    mstb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req.req_type),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the slot memory, the fill count, the limit
    // register and the response register.
    mstb_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .cmd         (cmd),
        .sts         (sts),
        .rsp_ready   (rsp_ready),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp)
    );

endmodule
